>>> rtl/core/sacd_pkg.sv
// Shared constants, types and pseudo-LRU helpers for the cache tag directory.
package sacd_pkg;

  localparam int unsigned NUM_SETS   = 128;
  localparam int unsigned NUM_WAYS   = 8;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LINE_SHIFT = 5;
  localparam int unsigned SET_W      = $clog2(NUM_SETS);
  localparam int unsigned WAY_W      = $clog2(NUM_WAYS);
  localparam int unsigned TAG_W      = ADDR_W - LINE_SHIFT - SET_W;
  localparam int unsigned EV_TAG_W   = 20;
  localparam int unsigned TREE_W     = NUM_WAYS - 1;

  typedef enum logic [1:0] {
    BR_NONE          = 2'd0,
    BR_LINE_READ     = 2'd1,
    BR_WRITE_THROUGH = 2'd2,
    BR_READ_EXCL     = 2'd3
  } bus_req_t;

  // per-set metadata row: tree bits and way valid bits
  typedef struct packed {
    logic [TREE_W-1:0]   plru;
    logic [NUM_WAYS-1:0] valid;
  } meta_t;

  typedef logic [NUM_WAYS-1:0][TAG_W-1:0] tag_row_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // request accepted: latch fields, read set rows
    logic resolve;  // rows valid: decide, write back, load result
  } dp_cmd_t;

  // walk the tree from the root; bit (NUM_WAYS-2-n) belongs to heap node n
  function automatic logic [WAY_W-1:0] plru_victim(input logic [TREE_W-1:0] tree);
    int unsigned n;
    n = 0;
    for (int l = 0; l < WAY_W; l++) begin
      n = 2 * n + 1 + (tree[NUM_WAYS-2-n] ? 1 : 0);
    end
    return WAY_W'(n - (NUM_WAYS - 1));
  endfunction

  // point every node on the way's path away from it
  function automatic logic [TREE_W-1:0] plru_touch(input logic [TREE_W-1:0] tree,
                                                   input logic [WAY_W-1:0]  way);
    int unsigned n;
    int unsigned p;
    logic [TREE_W-1:0] t;
    t = tree;
    n = 32'(way) + (NUM_WAYS - 1);
    for (int l = 0; l < WAY_W; l++) begin
      p = (n - 1) >> 1;
      t[NUM_WAYS-2-p] = n[0];
      n = p;
    end
    return t;
  endfunction

endpackage

>>> rtl/core/sacd_ctrl.sv
// Controller state machine: request sequencing and result register handshake.
module sacd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output sacd_pkg::dp_cmd_t cmd
);
  import sacd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RESOLVE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.resolve = (state_r == ST_RESOLVE) && slot_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (cmd.capture) state_nxt = ST_RESOLVE;
      ST_RESOLVE: if (cmd.resolve) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.resolve) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resolve |-> (!out_valid_r || out_ready))
    else $error("result overwritten while held");

  a_accept_then_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_RESOLVE))
    else $error("accepted request not taken to resolve");

  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.resolve))
    else $error("result appeared without resolve");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> !in_ready)
    else $error("second request taken while one in flight");

endmodule

>>> rtl/core/sacd_dpath.sv
// Datapath: set memories, tag compare, way choice, pseudo-LRU update, result register.
module sacd_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sacd_pkg::dp_cmd_t              cmd,
  input  logic                           in_cmd,
  input  logic [sacd_pkg::ADDR_W-1:0]    in_address,
  output logic                           out_hit,
  output logic [sacd_pkg::WAY_W-1:0]     out_way,
  output logic [1:0]                     out_bus_request,
  output logic                           out_evicted,
  output logic [sacd_pkg::EV_TAG_W-1:0]  out_evicted_tag
);
  import sacd_pkg::*;

  meta_t    meta_mem [NUM_SETS];
  tag_row_t tag_mem  [NUM_SETS];
  logic [NUM_SETS-1:0] row_init_r;  // row written since reset

  meta_t    meta_rd_r;
  tag_row_t tag_rd_r;
  logic     init_rd_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;
  logic             wr_r;

  logic [SET_W-1:0] in_set;
  logic [NUM_WAYS-1:0] valid, match;
  logic [TREE_W-1:0]   plru;
  logic                hit, have_free, evict;
  logic [WAY_W-1:0]    hit_way, free_way, victim, way_sel;
  logic [EV_TAG_W-1:0] ev_tag;
  bus_req_t            bus_req;
  meta_t               meta_wr;
  tag_row_t            tag_wr;

  assign in_set = in_address[LINE_SHIFT +: SET_W];

  always_comb begin
    valid = init_rd_r ? meta_rd_r.valid : '0;
    plru  = init_rd_r ? meta_rd_r.plru  : '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      match[w] = valid[w] && (tag_rd_r[w] == tag_r);
    end
    hit       = |match;
    have_free = ~&valid;
    hit_way   = '0;
    free_way  = '0;
    // downward so the lowest way wins
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (!valid[w]) free_way = WAY_W'(w);
    end
    victim  = plru_victim(plru);
    evict   = !hit && !have_free;
    way_sel = hit ? hit_way : (have_free ? free_way : victim);
    ev_tag  = evict ? EV_TAG_W'(tag_rd_r[victim]) : '0;
    if (hit) begin
      bus_req = wr_r ? BR_WRITE_THROUGH : BR_NONE;
    end else begin
      bus_req = wr_r ? BR_READ_EXCL : BR_LINE_READ;
    end
    meta_wr.valid          = valid;
    meta_wr.valid[way_sel] = 1'b1;
    meta_wr.plru           = plru_touch(plru, way_sel);
    tag_wr                 = tag_rd_r;
    if (!hit) tag_wr[way_sel] = tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (cmd.resolve) begin
      row_init_r[set_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meta_rd_r <= meta_mem[in_set];
      tag_rd_r  <= tag_mem[in_set];
      init_rd_r <= row_init_r[in_set];
      set_r     <= in_set;
      tag_r     <= in_address[ADDR_W-1 -: TAG_W];
      wr_r      <= in_cmd;
    end
    if (cmd.resolve) begin
      meta_mem[set_r]  <= meta_wr;
      tag_mem[set_r]   <= tag_wr;
      out_hit          <= hit;
      out_way          <= way_sel;
      out_bus_request  <= bus_req;
      out_evicted      <= evict;
      out_evicted_tag  <= ev_tag;
    end
  end

endmodule

>>> rtl/core/set_assoc_cache_plru_directory_top.sv
// Top level of the 8-way set-associative cache tag directory with tree pseudo-LRU.
//
// Usage: each request on the in_ channel carries a command (0 read, 1 write)
// and a byte address; bits 11:5 pick one of 128 sets, bits 31:12 are the tag.
// Every request yields exactly one result on the out_ channel: hit flag, the
// way hit or filled, the bus request to issue, and the evicted line's tag.
// A miss fills the lowest invalid way, or else the way the set's 7-bit tree
// points at; every request marks its way most recently used.
// Timing: capture registers the set rows of an accepted request, and the
// resolve step registers its result and raises out_valid. Throughput: a new
// request is taken only after the last one resolves - one step reads the
// set's metadata and tag rows from the set memories, the next compares,
// chooses the way and writes both rows back.
// Reset (rst_n low, synchronous) clears per-set row flags, so every set reads
// as all ways invalid with a zeroed tree; no clearing pass is needed.
// Stalls: a held result stays on out_ until taken, and the next request is
// still accepted meanwhile; its resolve step waits until the result register
// frees, so in_ready drops only while that request is in flight.
module set_assoc_cache_plru_directory_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [sacd_pkg::ADDR_W-1:0]    in_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [sacd_pkg::WAY_W-1:0]     out_way,
  output logic [1:0]                     out_bus_request,
  output logic                           out_evicted,
  output logic [sacd_pkg::EV_TAG_W-1:0]  out_evicted_tag
);
  import sacd_pkg::*;

  dp_cmd_t cmd;

  // sequencing of requests and the result handshake
  sacd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // set memories, lookup and replacement
  sacd_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cmd          (in_cmd),
    .in_address      (in_address),
    .out_hit         (out_hit),
    .out_way         (out_way),
    .out_bus_request (out_bus_request),
    .out_evicted     (out_evicted),
    .out_evicted_tag (out_evicted_tag)
  );

endmodule
